// ===== rtl/gha_pkg.sv =====
// Shared types, codes and helpers for the generational handle allocator.
package gha_pkg;

   localparam int SLOT_COUNT = 1024;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int GEN_W      = 32;
   localparam int LIVE_W     = 10;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   localparam logic [1:0] OP_CREATE  = 2'd0;
   localparam logic [1:0] OP_DESTROY = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_ALIVE = 2'd2;

   typedef struct packed {
      logic             alive;
      logic [GEN_W-1:0] gen;
   } slot_entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_entry_type   wr_data;
   } slot_req_type;

   // advance a generation, skipping zero on wrap
   function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
      logic [GEN_W-1:0] n;
      n = g + {{(GEN_W-1){1'b0}}, 1'b1};
      return (n == '0) ? {{(GEN_W-1){1'b0}}, 1'b1} : n;
   endfunction

endpackage

// ===== rtl/gha_slot_table.sv =====
// Per-slot alive bit and generation, one write and one registered read per cycle.
module gha_slot_table (
   input  logic                    clock,
   input  gha_pkg::slot_req_type   req,
   output gha_pkg::slot_entry_type rd_data
);

   gha_pkg::slot_entry_type mem [gha_pkg::SLOT_COUNT];
   gha_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/generational_handle_allocator_unit.sv =====
// Steps: fresh create goes IDLE, FINISH; create from the free stack IDLE, POP, POPGEN,
// FINISH; destroy or query IDLE, CHECK, FINISH (IDLE, FINISH for a handle out of range);
// clear IDLE, then CLEAR once per slot taken so far, then FINISH. One item in flight at
// a time, taken only in IDLE; the registered slot table read sets the step count.
// Reset is synchronous: counts and fill mark return to empty; tables are not swept,
// since entries at or above the fill mark are never read before being written.
module generational_handle_allocator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] opcode, [11:2] handle_index, [43:12] handle_generation, [47:44] zero
   input  logic [gha_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] status, [11:2] result_index, [43:12] result_generation, [44] is_alive,
   // [54:45] live_count, [55] zero
   output logic [gha_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_POP    = 3'd1;
   localparam logic [2:0] S_POPGEN = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_CLEAR  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   localparam int IW = gha_pkg::IDX_W;
   localparam int CW = gha_pkg::CNT_W;
   localparam int GW = gha_pkg::GEN_W;
   localparam int LW = gha_pkg::LIVE_W;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [CW-1:0] mark_ff, mark_in;
   logic [LW-1:0] live_ff, live_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [1:0]    op_ff, op_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [GW-1:0] gen_ff, gen_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [IW-1:0] pop_idx_ff, pop_idx_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [IW-1:0] res_idx_ff, res_idx_in;
   logic [GW-1:0] res_gen_ff, res_gen_in;
   logic          res_alive_ff, res_alive_in;
   logic [gha_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   gha_pkg::slot_req_type   slot_req;
   gha_pkg::slot_entry_type slot_rd;

   // free stack
   logic [IW-1:0] stack_mem [gha_pkg::SLOT_COUNT];
   logic [IW-1:0] stack_rd_ff;
   logic          stack_re;
   logic [IW-1:0] stack_raddr;
   logic          stack_we;
   logic [IW-1:0] stack_waddr;
   logic [IW-1:0] stack_wdata;

   logic [1:0]    req_op;
   logic [IW-1:0] req_idx;
   logic [GW-1:0] req_gen;
   logic          accept;
   logic          in_range;
   logic          match;
   logic [GW-1:0] pop_gen;

   assign req_op  = req_tdata[1:0];
   assign req_idx = req_tdata[11:2];
   assign req_gen = req_tdata[43:12];
   assign req_tready = (state_ff == S_IDLE);
   assign accept  = req_tvalid && req_tready;
   assign in_range = (req_idx != '0) && ({1'b0, req_idx} < mark_ff);
   assign match   = slot_rd.alive && (slot_rd.gen == gen_ff);
   assign pop_gen = (slot_rd.gen == '0) ? {{(GW-1){1'b0}}, 1'b1} : slot_rd.gen;

   gha_slot_table u_slot_table (
      .clock   (clock),
      .req     (slot_req),
      .rd_data (slot_rd)
   );

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_raddr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      mark_in       = mark_ff;
      live_in       = live_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      gen_in        = gen_ff;
      walk_in       = walk_ff;
      pop_idx_in    = pop_idx_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_gen_in    = res_gen_ff;
      res_alive_in  = res_alive_ff;
      rsp_data_in   = rsp_data_ff;

      slot_req      = '0;
      stack_re      = 1'b0;
      stack_raddr   = '0;
      stack_we      = 1'b0;
      stack_waddr   = '0;
      stack_wdata   = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               idx_in        = req_idx;
               gen_in        = req_gen;
               res_status_in = gha_pkg::ST_DONE;
               res_idx_in    = '0;
               res_gen_in    = '0;
               res_alive_in  = 1'b0;
               case (req_op)
                  gha_pkg::OP_CREATE: begin
                     if (depth_ff != '0) begin
                        depth_in    = depth_ff - {{(CW-1){1'b0}}, 1'b1};
                        stack_re    = 1'b1;
                        stack_raddr = depth_in[IW-1:0];
                        state_in    = S_POP;
                     end else if (mark_ff < CW'(gha_pkg::SLOT_COUNT)) begin
                        slot_req.wr_en         = 1'b1;
                        slot_req.wr_addr       = mark_ff[IW-1:0];
                        slot_req.wr_data.alive = 1'b1;
                        slot_req.wr_data.gen   = {{(GW-1){1'b0}}, 1'b1};
                        res_idx_in = mark_ff[IW-1:0];
                        res_gen_in = {{(GW-1){1'b0}}, 1'b1};
                        mark_in    = mark_ff + {{(CW-1){1'b0}}, 1'b1};
                        live_in    = live_ff + {{(LW-1){1'b0}}, 1'b1};
                        state_in   = S_FINISH;
                     end else begin
                        res_status_in = gha_pkg::ST_FULL;
                        state_in      = S_FINISH;
                     end
                  end
                  gha_pkg::OP_DESTROY, gha_pkg::OP_QUERY: begin
                     if (in_range) begin
                        slot_req.rd_en   = 1'b1;
                        slot_req.rd_addr = req_idx;
                        state_in         = S_CHECK;
                     end else begin
                        if (req_op == gha_pkg::OP_DESTROY) begin
                           res_status_in = gha_pkg::ST_NOT_ALIVE;
                        end
                        state_in = S_FINISH;
                     end
                  end
                  default: begin
                     // clear: empty the stack, then walk every taken slot, retiring it and pushing it back
                     depth_in = '0;
                     live_in  = '0;
                     walk_in  = {{(CW-1){1'b0}}, 1'b1};
                     if (mark_ff > {{(CW-1){1'b0}}, 1'b1}) begin
                        slot_req.rd_en   = 1'b1;
                        slot_req.rd_addr = {{(IW-1){1'b0}}, 1'b1};
                        state_in         = S_CLEAR;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
               endcase
            end
         end
         S_POP: begin
            pop_idx_in       = stack_rd_ff;
            slot_req.rd_en   = 1'b1;
            slot_req.rd_addr = stack_rd_ff;
            state_in         = S_POPGEN;
         end
         S_POPGEN: begin
            slot_req.wr_en         = 1'b1;
            slot_req.wr_addr       = pop_idx_ff;
            slot_req.wr_data.alive = 1'b1;
            slot_req.wr_data.gen   = pop_gen;
            res_idx_in = pop_idx_ff;
            res_gen_in = pop_gen;
            live_in    = live_ff + {{(LW-1){1'b0}}, 1'b1};
            state_in   = S_FINISH;
         end
         S_CHECK: begin
            if (op_ff == gha_pkg::OP_QUERY) begin
               res_alive_in = match;
            end else if (match) begin
               slot_req.wr_en         = 1'b1;
               slot_req.wr_addr       = idx_ff;
               slot_req.wr_data.alive = 1'b0;
               slot_req.wr_data.gen   = gha_pkg::next_gen(slot_rd.gen);
               stack_we    = 1'b1;
               stack_waddr = depth_ff[IW-1:0];
               stack_wdata = idx_ff;
               depth_in    = depth_ff + {{(CW-1){1'b0}}, 1'b1};
               if (live_ff != '0) begin
                  live_in = live_ff - {{(LW-1){1'b0}}, 1'b1};
               end
            end else begin
               res_status_in = gha_pkg::ST_NOT_ALIVE;
            end
            state_in = S_FINISH;
         end
         S_CLEAR: begin
            // retire slot walk_ff, prefetch the next one
            slot_req.wr_en         = 1'b1;
            slot_req.wr_addr       = walk_ff[IW-1:0];
            slot_req.wr_data.alive = 1'b0;
            slot_req.wr_data.gen   = gha_pkg::next_gen(slot_rd.gen);
            stack_we    = 1'b1;
            stack_waddr = IW'(walk_ff - {{(CW-1){1'b0}}, 1'b1});
            stack_wdata = walk_ff[IW-1:0];
            depth_in    = walk_ff;
            walk_in     = walk_ff + {{(CW-1){1'b0}}, 1'b1};
            if (walk_in < mark_ff) begin
               slot_req.rd_en   = 1'b1;
               slot_req.rd_addr = walk_in[IW-1:0];
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, live_ff, res_alive_ff, res_gen_ff, res_idx_ff,
                               res_status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         mark_ff      <= {{(CW-1){1'b0}}, 1'b1};
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         mark_ff      <= mark_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      gen_ff        <= gen_in;
      walk_ff       <= walk_in;
      pop_idx_ff    <= pop_idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_gen_ff    <= res_gen_in;
      res_alive_ff  <= res_alive_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
